[design/lidar_point_mask_classifier_macros.svh]
// Assertion macros for the checker file of the point classifier.
`ifndef LIDAR_POINT_MASK_CLASSIFIER_MACROS_SVH
`define LIDAR_POINT_MASK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define LPMC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpmc check failed");

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define LPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpmc check failed");

`endif

[design/lpmc_pkg.sv]
// Types and constants of the lidar point mask classifier.
`timescale 1ns / 1ps
package lpmc_pkg;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_MASK_WR  = 2'd1,
    OP_COEF_WR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CAT_OUT     = 2'd0,
    CAT_STATIC  = 2'd1,
    CAT_DYNAMIC = 2'd2
  } cat_e;

  typedef struct packed {
    op_e                op;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic [19:0]        write_index;
    logic signed [31:0] write_value;
  } in_req_t;

  typedef struct packed {
    cat_e        category;
    logic [10:0] pixel_u;
    logic [8:0]  pixel_v;
  } out_rsp_t;

  // Side data that rides along the pipeline with each request.
  typedef struct packed {
    op_e         op;
    logic [19:0] widx;
    logic        wbit;
    logic        drop;
    logic        ground;
  } meta_t;

  localparam int PW     = 52;        // coefficient times coordinate
  localparam int YW     = 54;        // projected row sum
  localparam int QB     = 13;        // quotient bits, top bit flags overflow
  localparam int PIX_W  = QB - 1;
  localparam int SW     = YW + QB - 1;
  localparam int NCOEF  = 12;

  localparam logic [1:0] REG_IMG_W  = 2'd0;
  localparam logic [1:0] REG_IMG_H  = 2'd1;
  localparam logic [1:0] REG_GROUND = 2'd2;

  localparam logic [11:0]        IMG_W_RST  = 12'd1242;
  localparam logic [9:0]         IMG_H_RST  = 10'd375;
  localparam logic signed [19:0] GROUND_RST = -20'sd1434;

  // Combined calibration matrix, Q11.20, row-major.
  localparam logic signed [31:0] CALIB_RESET [NCOEF] = '{
    32'sd640158286, -32'sd750737980, -32'sd11755494, -32'sd148438141,
    32'sd191953560, 32'sd10782296, -32'sd754276575, -32'sd98428630,
    32'sd1048560, 32'sd4882, -32'sd3075, -32'sd302129
  };

endpackage

[design/lpmc_proj.sv]
// Matrix store and the multiply and row-sum stages of the projection.
`timescale 1ns / 1ps
module lpmc_proj
  import lpmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  in_req_t               req_i,
  input  logic signed [19:0]    ground_i,
  output logic                  valid_o,
  output logic signed [YW-1:0]  y0_o,
  output logic signed [YW-1:0]  y1_o,
  output logic signed [YW-1:0]  y2_o,
  output meta_t                 meta_o
);

  logic signed [31:0]   mat_q [NCOEF];
  logic signed [19:0]   pt [3];
  logic signed [PW-1:0] prod_q [9];
  logic signed [31:0]   off_q [3];
  logic                 s1_vld_q;
  meta_t                s1_meta_q;
  meta_t                meta_d;
  logic signed [YW-1:0] y_q [3];
  logic                 s2_vld_q;
  meta_t                s2_meta_q;
  logic                 coef_wr;

  assign pt[0] = req_i.point_x;
  assign pt[1] = req_i.point_y;
  assign pt[2] = req_i.point_z;

  assign coef_wr = en_i && valid_i && (req_i.op == OP_COEF_WR)
                   && (req_i.write_index < 20'(NCOEF));

  // A coefficient write lands at accept, so later points see it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) mat_q[i] <= CALIB_RESET[i];
    end else if (coef_wr) begin
      mat_q[req_i.write_index[3:0]] <= req_i.write_value;
    end
  end

  always_comb begin
    meta_d        = '0;
    meta_d.op     = req_i.op;
    meta_d.widx   = req_i.write_index;
    meta_d.wbit   = (req_i.write_value != 32'sd0);
    meta_d.drop   = req_i.point_x[19];
    meta_d.ground = (req_i.point_z < ground_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_q[r*3+c] <= mat_q[r*4+c] * pt[c];
        off_q[r] <= mat_q[r*4+3];
      end
      s1_meta_q <= meta_d;
      for (int r = 0; r < 3; r++) begin
        y_q[r] <= YW'(prod_q[r*3]) + YW'(prod_q[r*3+1]) + YW'(prod_q[r*3+2])
                  + (YW'(off_q[r]) <<< 10);
      end
      s2_meta_q <= s1_meta_q;
    end
  end

  assign valid_o = s2_vld_q;
  assign y0_o    = y_q[0];
  assign y1_o    = y_q[1];
  assign y2_o    = y_q[2];
  assign meta_o  = s2_meta_q;

endmodule

[design/lpmc_div.sv]
// Two pipelined restoring dividers that share one divisor, one bit per stage.
`timescale 1ns / 1ps
module lpmc_div
  import lpmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [YW-1:0]  y0_i,
  input  logic signed [YW-1:0]  y1_i,
  input  logic signed [YW-1:0]  y2_i,
  input  meta_t                 meta_i,
  output logic                  valid_o,
  output logic [QB-1:0]         q0_o,
  output logic [QB-1:0]         q1_o,
  output logic                  neg0_o,
  output logic                  neg1_o,
  output meta_t                 meta_o
);

  logic [YW-1:0] r0_q [QB+1];
  logic [YW-1:0] r1_q [QB+1];
  logic [YW-1:0] d_q  [QB+1];
  logic [QB-1:0] q0_q [QB+1];
  logic [QB-1:0] q1_q [QB+1];
  logic          neg0_q [QB+1];
  logic          neg1_q [QB+1];
  meta_t         meta_q [QB+1];
  logic          vld_q  [QB+1];
  meta_t         meta_d;

  always_comb begin
    meta_d      = meta_i;
    meta_d.drop = meta_i.drop || y2_i[YW-1] || (y2_i == '0);
  end

  // Stage 0 takes magnitudes; a nonpositive divisor marks the point out of view.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q[0]   <= y0_i[YW-1] ? YW'(-y0_i) : YW'(y0_i);
      r1_q[0]   <= y1_i[YW-1] ? YW'(-y1_i) : YW'(y1_i);
      d_q[0]    <= YW'(y2_i);
      q0_q[0]   <= '0;
      q1_q[0]   <= '0;
      neg0_q[0] <= y0_i[YW-1];
      neg1_q[0] <= y1_i[YW-1];
      meta_q[0] <= meta_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QB; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s <= QB; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int K = QB - 1 - s;
    logic [SW-1:0] dsh;
    logic          ge0;
    logic          ge1;

    assign dsh = SW'(d_q[s]) << K;
    assign ge0 = (SW'(r0_q[s]) >= dsh);
    assign ge1 = (SW'(r1_q[s]) >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r0_q[s+1]   <= ge0 ? r0_q[s] - YW'(dsh) : r0_q[s];
        r1_q[s+1]   <= ge1 ? r1_q[s] - YW'(dsh) : r1_q[s];
        q0_q[s+1]   <= {q0_q[s][QB-2:0], ge0};
        q1_q[s+1]   <= {q1_q[s][QB-2:0], ge1};
        d_q[s+1]    <= d_q[s];
        neg0_q[s+1] <= neg0_q[s];
        neg1_q[s+1] <= neg1_q[s];
        meta_q[s+1] <= meta_q[s];
      end
    end
  end

  assign valid_o = vld_q[QB];
  assign q0_o    = q0_q[QB];
  assign q1_o    = q1_q[QB];
  assign neg0_o  = neg0_q[QB];
  assign neg1_o  = neg1_q[QB];
  assign meta_o  = meta_q[QB];

endmodule

[design/lpmc_mask.sv]
// View check, mask memory access and the result register.
`timescale 1ns / 1ps
module lpmc_mask
  import lpmc_pkg::*;
#(
  parameter int MASK_MAX_WIDTH  = 2048,
  parameter int MASK_MAX_HEIGHT = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [QB-1:0]  q0_i,
  input  logic [QB-1:0]  q1_i,
  input  logic           neg0_i,
  input  logic           neg1_i,
  input  meta_t          meta_i,
  input  logic [11:0]    img_w_i,
  input  logic [9:0]     img_h_i,
  output logic           valid_o,
  output out_rsp_t       rsp_o
);

  localparam int DEPTH = MASK_MAX_WIDTH * MASK_MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic             mem [DEPTH];

  logic [PIX_W-1:0] u;
  logic [PIX_W-1:0] v;
  logic             in_view;
  logic             wr_ok;
  logic [AW-1:0]    rd_addr;

  logic             a_vld_q, a_res_q, a_view_q, a_wr_q, a_wbit_q, a_gnd_q;
  logic [PIX_W-1:0] a_u_q, a_v_q;
  logic [AW-1:0]    a_addr_q;

  logic             b_vld_q, b_res_q, b_view_q, b_gnd_q, b_bit_q;
  logic [PIX_W-1:0] b_u_q, b_v_q;

  logic             out_vld_q;
  out_rsp_t         rsp_q;

  assign u = q0_i[PIX_W-1:0];
  assign v = q1_i[PIX_W-1:0];

  // A negative dividend only stays in view when its quotient truncates to zero.
  assign in_view = !meta_i.drop && !q0_i[QB-1] && !q1_i[QB-1]
                   && !(neg0_i && (q0_i != '0)) && !(neg1_i && (q1_i != '0))
                   && (u < img_w_i) && (32'(u) < 32'(MASK_MAX_WIDTH))
                   && (v < PIX_W'(img_h_i)) && (32'(v) < 32'(MASK_MAX_HEIGHT));

  assign wr_ok   = (meta_i.op == OP_MASK_WR) && (32'(meta_i.widx) < 32'(DEPTH));
  assign rd_addr = AW'(32'(v) * 32'(MASK_MAX_WIDTH) + 32'(u));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q   <= valid_i;
      b_vld_q   <= a_vld_q;
      out_vld_q <= b_vld_q && b_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_res_q  <= (meta_i.op == OP_CLASSIFY);
      a_view_q <= in_view;
      a_wr_q   <= wr_ok;
      a_wbit_q <= meta_i.wbit;
      a_gnd_q  <= meta_i.ground;
      a_u_q    <= u;
      a_v_q    <= v;
      a_addr_q <= wr_ok ? AW'(meta_i.widx) : rd_addr;

      b_res_q  <= a_res_q;
      b_view_q <= a_view_q;
      b_gnd_q  <= a_gnd_q;
      b_u_q    <= a_u_q;
      b_v_q    <= a_v_q;
    end
  end

  // Writes and reads meet at the same stage, so they keep request order.
  always_ff @(posedge clk_i) begin
    if (en_i && a_vld_q && a_wr_q) begin
      mem[a_addr_q] <= a_wbit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_bit_q <= mem[a_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!b_view_q) begin
        rsp_q <= '{category: CAT_OUT, pixel_u: '0, pixel_v: '0};
      end else begin
        rsp_q.category <= (!b_bit_q || b_gnd_q) ? CAT_STATIC : CAT_DYNAMIC;
        rsp_q.pixel_u  <= b_u_q[10:0];
        rsp_q.pixel_v  <= b_v_q[8:0];
      end
    end
  end

  assign valid_o = out_vld_q;
  assign rsp_o   = rsp_q;

endmodule

[design/lidar_point_mask_classifier.sv]
// Top level of the lidar point mask classifier.
//
//   channel   direction  handshake            payload
//   in        request    in_valid_i/in_ready_o   in_req_i (in_req_t)
//   out       result     out_valid_o/out_ready_i out_rsp_o (out_rsp_t)
//   cfg       APB rd/wr  psel/penable/pwrite     paddr, pwdata, prdata
//
// One request per cycle while in_ready_o is high; a classify request passes 19
// register stages from accept to result, most of them the 14 of the divider lanes.
// Mask and coefficient writes give no result.
// Reset restores the calibration matrix and registers; mask bits stay undefined.
// A stalled result register freezes the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps
module lidar_point_mask_classifier
  import lpmc_pkg::*;
#(
  parameter int MASK_MAX_WIDTH  = 2048,
  parameter int MASK_MAX_HEIGHT = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_rsp_t    out_rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 en;
  logic [11:0]          img_w_q;
  logic [9:0]           img_h_q;
  logic signed [19:0]   ground_q;

  logic                 p_vld;
  logic signed [YW-1:0] p_y0, p_y1, p_y2;
  meta_t                p_meta;

  logic                 d_vld;
  logic [QB-1:0]        d_q0, d_q1;
  logic                 d_neg0, d_neg1;
  meta_t                d_meta;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign pready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= IMG_W_RST;
      img_h_q  <= IMG_H_RST;
      ground_q <= GROUND_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_IMG_W:  img_w_q  <= pwdata[11:0];
        REG_IMG_H:  img_h_q  <= pwdata[9:0];
        REG_GROUND: ground_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMG_W:  prdata = {20'b0, img_w_q};
      REG_IMG_H:  prdata = {22'b0, img_h_q};
      REG_GROUND: prdata = {{12{ground_q[19]}}, ground_q};
      default:    prdata = '0;
    endcase
  end

  lpmc_proj u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .req_i    (in_req_i),
    .ground_i (ground_q),
    .valid_o  (p_vld),
    .y0_o     (p_y0),
    .y1_o     (p_y1),
    .y2_o     (p_y2),
    .meta_o   (p_meta)
  );

  lpmc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_vld),
    .y0_i    (p_y0),
    .y1_i    (p_y1),
    .y2_i    (p_y2),
    .meta_i  (p_meta),
    .valid_o (d_vld),
    .q0_o    (d_q0),
    .q1_o    (d_q1),
    .neg0_o  (d_neg0),
    .neg1_o  (d_neg1),
    .meta_o  (d_meta)
  );

  lpmc_mask #(
    .MASK_MAX_WIDTH  (MASK_MAX_WIDTH),
    .MASK_MAX_HEIGHT (MASK_MAX_HEIGHT)
  ) u_mask (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .q0_i    (d_q0),
    .q1_i    (d_q1),
    .neg0_i  (d_neg0),
    .neg1_i  (d_neg1),
    .meta_i  (d_meta),
    .img_w_i (img_w_q),
    .img_h_i (img_h_q),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

endmodule

[design/lpmc_checker.sv]
// Port-level checks of the lidar point mask classifier, bound to the top level.
`timescale 1ns / 1ps
`include "lidar_point_mask_classifier_macros.svh"
module lpmc_checker
  import lpmc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_rsp_t    out_rsp_o
);

  // A held result must not move.
  `LPMC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // Requests are taken exactly when the result register can move.
  `LPMC_ASSERT_IMPL(a_ready_link, 1'b1, in_ready_o == (!out_valid_o || out_ready_i))

  // Out-of-view results carry zero pixels.
  `LPMC_ASSERT_IMPL(a_out_zero, out_valid_o && (out_rsp_o.category == CAT_OUT),
                    (out_rsp_o.pixel_u == '0) && (out_rsp_o.pixel_v == '0))

endmodule

bind lidar_point_mask_classifier lpmc_checker u_lpmc_checker (.*);
